/* rtl/fpmd_pkg.sv */
// package for the fixed-point multiply/divide unit
// types, opcodes and default constants; no dependencies
`timescale 1ns / 1ps

package fpmd_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DIV_W         = 64;

    typedef enum logic [1:0] {
        OP_RMUL  = 2'd0,
        OP_MSHF  = 2'd1,
        OP_DIV   = 2'd2,
        OP_SCALE = 2'd3
    } t_op;

    // word carried along the divider cell chain
    typedef struct packed {
        logic              valid;
        t_op               op;
        logic              neg;
        logic              dz;
        logic [DIV_W-1:0]  rem;
        logic [DIV_W-1:0]  quo;
        logic [DIV_W-1:0]  dvs;
        logic [31:0]       res;
    } t_cell;

endpackage

/* rtl/fpmd_if.sv */
// valid/ready channel interface for the fixed-point multiply/divide unit
// depends on nothing
`timescale 1ns / 1ps

interface fpmd_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic [31:0] scale_divisor;
    logic [5:0]  shift_amount;
    modport source (output valid, opcode, operand_a, operand_b, scale_divisor,
                    shift_amount, input ready);
    modport sink (input valid, opcode, operand_a, operand_b, scale_divisor,
                  shift_amount, output ready);
endinterface

interface fpmd_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result;
    logic        divide_by_zero;
    modport source (output valid, result, divide_by_zero, input ready);
    modport sink (input valid, result, divide_by_zero, output ready);
endinterface

/* rtl/fixed_point_mul_div_unit.sv */
// Fixed-point multiply/divide unit, Q(32-FRAC_BITS).FRAC_BITS. One word is accepted per
// cycle unless the pipeline stalls. Every opcode passes through one multiply stage, one
// stage that forms magnitudes and the multiply results, a chain of 64 division cells
// (one quotient bit each), and an output register. The stall moves the whole pipeline
// together, so throughput is one word per cycle while the sink takes words.
// depends on fpmd_pkg, fpmd_if, fpmd_cell
`timescale 1ns / 1ps

module fixed_point_mul_div_unit #(
    parameter int FRAC_BITS = fpmd_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fpmd_in_if.sink       i_in,
    fpmd_out_if.source    o_out
);

    localparam int W    = fpmd_pkg::DIV_W;
    localparam int NCEL = W;

    logic w_en;

    // stage 1: product
    logic               r_v1;
    fpmd_pkg::t_op      r_op1;
    logic signed [63:0] r_prod1;
    logic signed [31:0] r_a1;
    logic signed [31:0] r_b1;
    logic signed [31:0] r_c1;
    logic [5:0]         r_sh1;

    fpmd_pkg::t_cell w_chain [NCEL+1];
    fpmd_pkg::t_cell n_head;

    logic        r_ov;
    logic [31:0] r_res;
    logic        r_dz;

    assign w_en       = !r_ov || o_out.ready;
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_in.valid;
        end
        if (w_en) begin
            r_op1   <= fpmd_pkg::t_op'(i_in.opcode);
            r_prod1 <= $signed(i_in.operand_a) * $signed(i_in.operand_b);
            r_a1    <= i_in.operand_a;
            r_b1    <= i_in.operand_b;
            r_c1    <= i_in.scale_divisor;
            r_sh1   <= i_in.shift_amount;
        end
    end

    // stage 2 inputs: dividend, divisor and non-dividing results
    logic signed [63:0] w_sum;
    logic signed [63:0] w_num;
    logic signed [63:0] w_den;
    logic [63:0]        w_nmag;
    logic [63:0]        w_dmag;

    always_comb begin
        w_sum = r_prod1 + (64'sd1 <<< (FRAC_BITS - 1));
        if (r_op1 == fpmd_pkg::OP_DIV) begin
            w_num = {{(32 - FRAC_BITS){r_a1[31]}}, r_a1, {FRAC_BITS{1'b0}}};
            w_den = 64'(r_b1);
        end else begin
            w_num = r_prod1;
            w_den = 64'(r_c1);
        end
        w_nmag = w_num[63] ? (64'd0 - w_num) : w_num;
        w_dmag = w_den[63] ? (64'd0 - w_den) : w_den;

        n_head       = '0;
        n_head.valid = r_v1;
        n_head.op    = r_op1;
        n_head.neg   = w_num[63] ^ w_den[63];
        n_head.dvs   = w_dmag;
        n_head.quo   = w_nmag;
        unique case (r_op1)
            fpmd_pkg::OP_RMUL: n_head.res = 32'(w_sum >>> FRAC_BITS);
            fpmd_pkg::OP_MSHF: n_head.res = 32'(r_prod1 >> r_sh1);
            default:           n_head.dz  = (w_den == 64'sd0);
        endcase
    end

    fpmd_pkg::t_cell r_head;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head.valid <= 1'b0;
        end else if (w_en) begin
            r_head.valid <= n_head.valid;
        end
        if (w_en) begin
            r_head.op  <= n_head.op;
            r_head.neg <= n_head.neg;
            r_head.dz  <= n_head.dz;
            r_head.rem <= n_head.rem;
            r_head.quo <= n_head.quo;
            r_head.dvs <= n_head.dvs;
            r_head.res <= n_head.res;
        end
    end
    assign w_chain[0] = r_head;

    for (genvar g = 0; g < NCEL; g++) begin : g_cell
        fpmd_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_cell (w_chain[g]),
            .o_cell (w_chain[g+1])
        );
    end

    fpmd_pkg::t_cell w_tail;
    logic [31:0]     w_q;
    assign w_tail = w_chain[NCEL];
    assign w_q    = w_tail.neg ? (32'd0 - w_tail.quo[31:0]) : w_tail.quo[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= w_tail.valid;
        end
        if (w_en) begin
            if (w_tail.op == fpmd_pkg::OP_RMUL || w_tail.op == fpmd_pkg::OP_MSHF) begin
                r_res <= w_tail.res;
                r_dz  <= 1'b0;
            end else if (w_tail.dz) begin
                r_res <= '0;
                r_dz  <= 1'b1;
            end else begin
                r_res <= w_q;
                r_dz  <= 1'b0;
            end
        end
    end

    assign o_out.valid          = r_ov;
    assign o_out.result         = r_res;
    assign o_out.divide_by_zero = r_dz;

endmodule

/* rtl/fpmd_cell.sv */
// one restoring-division cell: one quotient bit per stage, registered
// depends on fpmd_pkg
`timescale 1ns / 1ps

module fpmd_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  fpmd_pkg::t_cell i_cell,
    output fpmd_pkg::t_cell o_cell
);

    fpmd_pkg::t_cell r_cell;
    fpmd_pkg::t_cell n_cell;
    logic [fpmd_pkg::DIV_W:0] w_trial;
    logic [fpmd_pkg::DIV_W:0] w_sub;

    always_comb begin
        n_cell = i_cell;
        // shift next dividend bit (msb of quo) into the remainder
        w_trial = {i_cell.rem, i_cell.quo[fpmd_pkg::DIV_W-1]};
        w_sub   = w_trial - {1'b0, i_cell.dvs};
        n_cell.quo = {i_cell.quo[fpmd_pkg::DIV_W-2:0], ~w_sub[fpmd_pkg::DIV_W]};
        if (w_sub[fpmd_pkg::DIV_W]) begin
            n_cell.rem = w_trial[fpmd_pkg::DIV_W-1:0];
        end else begin
            n_cell.rem = w_sub[fpmd_pkg::DIV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell.valid <= i_cell.valid;
        end
        if (i_en) begin
            r_cell.op  <= n_cell.op;
            r_cell.neg <= n_cell.neg;
            r_cell.dz  <= n_cell.dz;
            r_cell.rem <= n_cell.rem;
            r_cell.quo <= n_cell.quo;
            r_cell.dvs <= n_cell.dvs;
            r_cell.res <= n_cell.res;
        end
    end

    assign o_cell = r_cell;

endmodule

/* tb/sv/tb.sv */
// testbench for fixed_point_mul_div_unit: directed table then random words,
// checked against a behavioral predictor; depends on fpmd_pkg, fpmd_if and the rtl
`timescale 1ns / 1ps

module tb;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 100;
    localparam int RANDOM_PER_PHASE = 135;

    typedef struct {
        fpmd_pkg::t_op      op;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic [5:0]         sh;
        bit                 typed;
        logic [31:0]        res;
        logic               dz;
    } t_row;

    typedef struct {
        logic [31:0] res;
        logic        dz;
    } t_answer;

    logic i_clk;
    logic i_rst_n;

    fpmd_in_if  in_ch ();
    fpmd_out_if out_ch ();

    fixed_point_mul_div_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    t_answer pending_answers[$];
    t_answer typed_answers[$];
    bit      typed_flags[$];
    int      errors;
    int      send_idle_pct;
    int      recv_stall_pct;
    int      idle_cycles = 0;
    int      op_count[4];
    int      dz_seen;
    int      words_out;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic t_answer predict_mul_div(fpmd_pkg::t_op op, logic signed [31:0] a,
                                                logic signed [31:0] b,
                                                logic signed [31:0] c, logic [5:0] sh);
        t_answer     ans;
        longint      prod;
        longint      quo;
        logic [63:0] bits;
        prod    = longint'(a) * longint'(b);
        ans.res = '0;
        ans.dz  = 1'b0;
        case (op)
            fpmd_pkg::OP_RMUL: begin
                quo     = (prod + 64'sd32768) >>> 16;
                ans.res = quo[31:0];
            end
            fpmd_pkg::OP_MSHF: begin
                bits    = prod;
                bits    = bits >> sh;
                ans.res = bits[31:0];
            end
            fpmd_pkg::OP_DIV: begin
                if (b == 0) begin
                    ans.dz = 1'b1;
                end else begin
                    quo     = (longint'(a) * 64'sd65536) / longint'(b);
                    ans.res = quo[31:0];
                end
            end
            default: begin
                if (c == 0) begin
                    ans.dz = 1'b1;
                end else begin
                    quo     = prod / longint'(c);
                    ans.res = quo[31:0];
                end
            end
        endcase
        return ans;
    endfunction

    // record expectation for every accepted input word
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            pending_answers.push_back(predict_mul_div(fpmd_pkg::t_op'(in_ch.opcode),
                                                      in_ch.operand_a,
                                                      in_ch.operand_b, in_ch.scale_divisor,
                                                      in_ch.shift_amount));
            op_count[in_ch.opcode]++;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_answer exp_ans;
        t_answer row_ans;
        bit      has_row;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            words_out++;
            if (out_ch.divide_by_zero) dz_seen++;
            if (pending_answers.size() == 0) begin
                $error("result word with nothing expected: result=%h divide_by_zero=%b",
                       out_ch.result, out_ch.divide_by_zero);
                errors++;
            end else begin
                exp_ans = pending_answers.pop_front();
                has_row = typed_flags.pop_front();
                row_ans = typed_answers.pop_front();
                // typed table values override nothing, they must agree with the predictor too
                if (has_row && (row_ans.res !== exp_ans.res || row_ans.dz !== exp_ans.dz)) begin
                    $error("table row disagrees with predictor: result exp %h pred %h",
                           row_ans.res, exp_ans.res);
                    errors++;
                end
                if (out_ch.result !== exp_ans.res) begin
                    $error("result: expected %h, actual %h", exp_ans.res, out_ch.result);
                    errors++;
                end
                if (out_ch.divide_by_zero !== exp_ans.dz) begin
                    $error("divide_by_zero: expected %b, actual %b", exp_ans.dz,
                           out_ch.divide_by_zero);
                    errors++;
                end
            end
        end
    end

    // receiver stalls
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles without any accepted word
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_word(t_row row);
        t_answer ans;
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.opcode        <= row.op;
        in_ch.operand_a     <= row.a;
        in_ch.operand_b     <= row.b;
        in_ch.scale_divisor <= row.c;
        in_ch.shift_amount  <= row.sh;
        ans.res = row.res;
        ans.dz  = row.dz;
        typed_flags.push_back(row.typed);
        typed_answers.push_back(ans);
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        // let the last accepted word reach the expectation queue first
        @(posedge i_clk);
        while (pending_answers.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'(signed'($urandom_range(0, 8)) - 4);
            3:       return 32'(signed'($urandom_range(0, 1 << 20)) - (1 << 19));
            4:       return 32'h0001_0000;
            default: return $urandom;
        endcase
    endfunction

    t_row directed[] = '{
        '{fpmd_pkg::OP_DIV, 32'sd5, 32'sd0, 32'sd3, 6'd0, 1'b1, 32'h0, 1'b1},
        '{fpmd_pkg::OP_SCALE, 32'sd5, 32'sd9, 32'sd0, 6'd0, 1'b1, 32'h0, 1'b1},
        '{fpmd_pkg::OP_RMUL, 32'sd0, 32'h80000000, 32'sd0, 6'd0, 1'b1, 32'h0, 1'b0},
        '{fpmd_pkg::OP_RMUL, 32'h00010000, 32'h7fffffff, 32'sd0, 6'd0, 1'b1, 32'h7fffffff, 1'b0},
        '{fpmd_pkg::OP_RMUL, 32'sd1, 32'sd1, 32'sd0, 6'd0, 1'b1, 32'h0, 1'b0},
        '{fpmd_pkg::OP_RMUL, -32'sd1, 32'sd1, 32'sd0, 6'd0, 1'b1, 32'h0, 1'b0},
        '{fpmd_pkg::OP_MSHF, 32'sd1, 32'sd1, 32'sd0, 6'd0, 1'b1, 32'h1, 1'b0},
        '{fpmd_pkg::OP_MSHF, -32'sd1, 32'sd1, 32'sd0, 6'd63, 1'b1, 32'h1, 1'b0},
        '{fpmd_pkg::OP_MSHF, 32'h80000000, 32'h80000000, 32'sd0, 6'd32, 1'b1, 32'h40000000, 1'b0},
        '{fpmd_pkg::OP_MSHF, 32'sd0, 32'sd0, 32'sd0, 6'd5, 1'b1, 32'h0, 1'b0},
        '{fpmd_pkg::OP_DIV, 32'sd1, 32'sd1, 32'sd0, 6'd0, 1'b1, 32'h0001_0000, 1'b0},
        '{fpmd_pkg::OP_DIV, 32'h8000_0000, -32'sd1, 32'sd0, 6'd0, 1'b1, 32'h0, 1'b0},
        '{fpmd_pkg::OP_SCALE, 32'h80000000, 32'h80000000, 32'sd1, 6'd0, 1'b1, 32'h0, 1'b0},
        '{fpmd_pkg::OP_SCALE, 32'sd7, 32'sd3, -32'sd2, 6'd0, 1'b1, 32'hffff_fff6, 1'b0},
        '{fpmd_pkg::OP_RMUL, 32'h7fff_ffff, 32'h7fff_ffff, 32'sd0, 6'd0, 1'b0, 32'h0, 1'b0},
        '{fpmd_pkg::OP_RMUL, 32'h8000_0000, 32'h7fff_ffff, 32'sd0, 6'd0, 1'b0, 32'h0, 1'b0},
        '{fpmd_pkg::OP_RMUL, 32'h8000_0000, 32'h8000_0000, 32'sd7, 6'd9, 1'b0, 32'h0, 1'b0},
        '{fpmd_pkg::OP_MSHF, 32'h7fff_ffff, 32'h8000_0000, 32'sd0, 6'd17, 1'b0, 32'h0, 1'b0},
        '{fpmd_pkg::OP_MSHF, 32'h8000_0000, 32'h7fff_ffff, 32'sd0, 6'd63, 1'b0, 32'h0, 1'b0},
        '{fpmd_pkg::OP_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'sd0, 6'd0, 1'b0, 32'h0, 1'b0},
        '{fpmd_pkg::OP_DIV, -32'sd7, 32'sd2, 32'sd0, 6'd0, 1'b0, 32'h0, 1'b0},
        '{fpmd_pkg::OP_SCALE, 32'h7fff_ffff, 32'h7fff_ffff, -32'sd1, 6'd0, 1'b0, 32'h0, 1'b0},
        '{fpmd_pkg::OP_SCALE, -32'sd9, 32'sd4, 32'sd5, 6'd0, 1'b0, 32'h0, 1'b0}
    };

    initial begin
        t_row row;
        int   phase;
        in_ch.valid         <= 1'b0;
        in_ch.opcode        <= fpmd_pkg::OP_RMUL;
        in_ch.operand_a     <= '0;
        in_ch.operand_b     <= '0;
        in_ch.scale_divisor <= '0;
        in_ch.shift_amount  <= '0;
        i_rst_n             <= 1'b0;
        errors         = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        dz_seen        = 0;
        words_out      = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) send_word(directed[i]);
        // hold the sender until the pipeline is empty
        drain_results();

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            repeat (RANDOM_PER_PHASE) begin
                row.op    = fpmd_pkg::t_op'($urandom_range(3));
                row.a     = pick_operand();
                row.b     = ($urandom_range(9) == 0) ? 32'sd0 : pick_operand();
                row.c     = ($urandom_range(9) == 0) ? 32'sd0 : pick_operand();
                row.sh    = 6'($urandom_range(63));
                row.typed = 1'b0;
                row.res   = '0;
                row.dz    = 1'b0;
                send_word(row);
            end
            if (phase == 1) drain_results();
        end
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d result words: %0d round-mul, %0d mul-shift, %0d divide, %0d scale",
                 words_out, op_count[0], op_count[1], op_count[2], op_count[3]);
        $display("%0d zero-divisor results, four sender/receiver idling phases", dz_seen);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* fixed_point_mul_div_unit.f */
rtl/fpmd_pkg.sv
rtl/fpmd_if.sv
rtl/fpmd_cell.sv
rtl/fixed_point_mul_div_unit.sv
tb/sv/tb.sv
